// ===== hw/rtl/col_pkg.sv =====
// Shared constants, types and datapath step functions for the circle obstacle path block.
// Used by col_front, col_fifo, col_back and the top level. Depends on nothing.
package col_pkg;

	localparam int COORD_BITS = 14;
	localparam int FRAC_BITS  = 12;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int DIF_BITS   = COORD_BITS + 1;
	localparam int PRD_BITS   = 2 * DIF_BITS;
	localparam int SUM_BITS   = PRD_BITS + 1;
	localparam int MAG_BITS   = PRD_BITS;
	localparam int R2_BITS    = 2 * RAD_BITS;

	localparam int SQ_PAIRS   = MAG_BITS / 2;
	localparam int SQRT_STEPS = SQ_PAIRS + FRAC_BITS;
	localparam int ROOT_BITS  = SQRT_STEPS;
	localparam int REM_BITS   = ROOT_BITS + 2;

	localparam int LEN_BITS     = 29;
	localparam int ANG_BITS     = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int NORM_BITS    = 41;
	localparam int NORM_STEPS   = $clog2(NORM_BITS);
	localparam int CX_BITS      = NORM_BITS + 3;
	localparam int QA_BITS      = ANG_BITS + 1;
	localparam int Z_BITS       = ANG_BITS + 2;
	localparam int THETA_BITS   = ANG_BITS + 2;
	localparam int PROD_BITS    = RAD_BITS + THETA_BITS;
	localparam int ARC_RND_SH   = ANG_BITS - FRAC_BITS;

	localparam int NUM_LANES   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int BACK_STAGES = SQRT_STEPS + NORM_STEPS + CORDIC_STEPS + 4;

	localparam logic [THETA_BITS-1:0] PI_Q      = 32'd3373259426;
	localparam logic [QA_BITS-1:0]    HALF_PI_Q = 31'd1686629713;

	localparam logic [QA_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
		31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
		31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536,
		31'd32768, 31'd16384, 31'd8192, 31'd4096, 31'd2048,
		31'd1024, 31'd512, 31'd256, 31'd128, 31'd64,
		31'd32, 31'd16, 31'd8, 31'd4, 31'd2
	};

	// classified query, front to back
	typedef struct packed {
		logic                straight;
		logic [RAD_BITS-1:0] r;
		logic [MAG_BITS-1:0] d2;
		logic [MAG_BITS-1:0] ta;
		logic [MAG_BITS-1:0] tb;
		logic [MAG_BITS-1:0] crs;
		logic [MAG_BITS-1:0] dcm;
		logic                dcneg;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic                straight;
		logic [RAD_BITS-1:0] r;
		logic [MAG_BITS-1:0] crs;
		logic [MAG_BITS-1:0] dcm;
		logic                dcneg;
	} sqsb_t;

	typedef struct packed {
		logic                 straight;
		logic [RAD_BITS-1:0]  r;
		logic [ROOT_BITS-1:0] d2r;
		logic [ROOT_BITS-1:0] t1;
		logic [ROOT_BITS-1:0] t2;
		logic                 dcneg;
		logic [NUM_LANES-1:0] zero;
	} cosb_t;

	typedef struct packed {
		logic [MAG_BITS-1:0]  x;
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [NORM_BITS-1:0] x;
		logic [NORM_BITS-1:0] y;
	} nv_t;

	typedef struct packed {
		logic signed [CX_BITS-1:0] x;
		logic signed [CX_BITS-1:0] y;
		logic signed [Z_BITS-1:0]  z;
	} cs_t;

	function automatic logic [MAG_BITS-1:0] mag(input logic signed [SUM_BITS-1:0] v);
		logic signed [SUM_BITS-1:0] n;
		n = -v;
		return v[SUM_BITS-1] ? MAG_BITS'(n) : MAG_BITS'(v);
	endfunction

	// one restoring square root step: bring down the next bit pair
	function automatic sq_t sqrt_step(input sq_t s);
		sq_t                 o;
		logic [REM_BITS-1:0] rem2;
		logic [REM_BITS-1:0] trial;
		rem2  = {s.rem[REM_BITS-3:0], s.x[MAG_BITS-1 -: 2]};
		trial = {s.root, 2'b01};
		o.x   = s.x << 2;
		if (rem2 >= trial) begin
			o.rem  = rem2 - trial;
			o.root = {s.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			o.rem  = rem2;
			o.root = {s.root[ROOT_BITS-2:0], 1'b0};
		end
		return o;
	endfunction

	// one stage of the leading-zero shift: test the top sh bits, shift both if clear
	function automatic nv_t norm_step(input nv_t v, input int k);
		nv_t o;
		int  sh;
		sh = 1 << (NORM_STEPS - 1 - k);
		o  = v;
		if (((v.x | v.y) >> (NORM_BITS - sh)) == '0) begin
			o.x = v.x << sh;
			o.y = v.y << sh;
		end
		return o;
	endfunction

	function automatic cs_t cordic_step(input cs_t s, input int i);
		cs_t                       o;
		logic signed [CX_BITS-1:0] cx;
		logic signed [CX_BITS-1:0] cy;
		logic signed [Z_BITS-1:0]  za;
		cx = s.x;
		cy = s.y;
		za = $signed({1'b0, ATAN_TAB[i]});
		if (!cy[CX_BITS-1]) begin
			o.x = cx + (cy >>> i);
			o.y = cy - (cx >>> i);
			o.z = s.z + za;
		end else begin
			o.x = cx - (cy >>> i);
			o.y = cy + (cx >>> i);
			o.z = s.z - za;
		end
		return o;
	endfunction

	function automatic logic [QA_BITS-1:0] clamp_ang(input logic signed [Z_BITS-1:0] z,
			input logic zero);
		if (zero || z[Z_BITS-1])
			return '0;
		if (z > $signed({1'b0, HALF_PI_Q}))
			return HALF_PI_Q;
		return z[QA_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/col_front.sv =====
// Front end: accepts queries, forms the exact integer products and classifies each
// query as straight or wrapped. Uses col_pkg; pushes into col_fifo.
module col_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [col_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [col_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [col_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [col_pkg::COORD_BITS-1:0] end_y,
	input  logic signed [col_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [col_pkg::COORD_BITS-1:0] center_y,
	input  logic [col_pkg::RAD_BITS-1:0]          radius,
	input  col_pkg::q_stat_t                      q_stat,
	output logic                                  push,
	output col_pkg::item_t                        push_item
);
	import col_pkg::*;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [COORD_BITS-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic [RAD_BITS-1:0]          r_s1, r_s2, r_s3, r_s4;

	logic signed [DIF_BITS-1:0] ux, uy, vcx, vcy, wx, wy, pax, pay, pbx, pby;

	logic signed [PRD_BITS-1:0] p_uvcy_s2, p_uvcx_s2, p_uwx_s2, p_uwy_s2, p_uvx_s2, p_uvy_s2;
	logic signed [PRD_BITS-1:0] p_abx_s2, p_aby_s2, p_axby_s2, p_aybx_s2;
	logic [MAG_BITS-1:0]        sq_ux_s2, sq_uy_s2, sq_pax_s2, sq_pay_s2, sq_pbx_s2, sq_pby_s2;
	logic [R2_BITS-1:0]         r2_s2, r2_s3;

	logic signed [SUM_BITS-1:0] cp, dc, cr, dta, dtb;
	logic signed [SUM_BITS-1:0] dta_s3, dtb_s3;
	logic [MAG_BITS-1:0]        cpa_s3, d2_s3, da_s3, db_s3, crs_s3, dcm_s3;
	logic                       dcneg_s3, dcneg_s4;

	logic [2*MAG_BITS-1:0]       lhs_s4;
	logic [R2_BITS+MAG_BITS-1:0] rhs_s4;
	logic [MAG_BITS-1:0]         dtm_s4, d2_s4, ta_s4, tb_s4, crs_s4, dcm_s4;

	// hold the whole front while its last stage cannot push
	assign en       = !(vld_s4 && q_stat.full);
	assign in_stall = !en;
	assign push     = vld_s4 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign ux  = DIF_BITS'(bx_s1) - DIF_BITS'(ax_s1);
	assign uy  = DIF_BITS'(by_s1) - DIF_BITS'(ay_s1);
	assign vcx = DIF_BITS'(cx_s1) - DIF_BITS'(ax_s1);
	assign vcy = DIF_BITS'(cy_s1) - DIF_BITS'(ay_s1);
	assign wx  = DIF_BITS'(cx_s1) - DIF_BITS'(bx_s1);
	assign wy  = DIF_BITS'(cy_s1) - DIF_BITS'(by_s1);
	assign pax = DIF_BITS'(ax_s1) - DIF_BITS'(cx_s1);
	assign pay = DIF_BITS'(ay_s1) - DIF_BITS'(cy_s1);
	assign pbx = DIF_BITS'(bx_s1) - DIF_BITS'(cx_s1);
	assign pby = DIF_BITS'(by_s1) - DIF_BITS'(cy_s1);

	always_comb begin
		cp  = SUM_BITS'(p_uvcy_s2) - SUM_BITS'(p_uvcx_s2);
		dc  = SUM_BITS'(p_abx_s2) + SUM_BITS'(p_aby_s2);
		cr  = SUM_BITS'(p_axby_s2) - SUM_BITS'(p_aybx_s2);
		dta = -(SUM_BITS'(p_uwx_s2) + SUM_BITS'(p_uwy_s2));
		dtb = SUM_BITS'(p_uvx_s2) + SUM_BITS'(p_uvy_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= start_x;
			ay_s1 <= start_y;
			bx_s1 <= end_x;
			by_s1 <= end_y;
			cx_s1 <= center_x;
			cy_s1 <= center_y;
			r_s1  <= radius;

			p_uvcy_s2 <= ux * vcy;
			p_uvcx_s2 <= uy * vcx;
			p_uwx_s2  <= ux * wx;
			p_uwy_s2  <= uy * wy;
			p_uvx_s2  <= ux * vcx;
			p_uvy_s2  <= uy * vcy;
			p_abx_s2  <= pax * pbx;
			p_aby_s2  <= pay * pby;
			p_axby_s2 <= pax * pby;
			p_aybx_s2 <= pay * pbx;
			sq_ux_s2  <= ux * ux;
			sq_uy_s2  <= uy * uy;
			sq_pax_s2 <= pax * pax;
			sq_pay_s2 <= pay * pay;
			sq_pbx_s2 <= pbx * pbx;
			sq_pby_s2 <= pby * pby;
			r2_s2     <= r_s1 * r_s1;
			r_s2      <= r_s1;

			cpa_s3   <= mag(cp);
			d2_s3    <= sq_ux_s2 + sq_uy_s2;
			da_s3    <= sq_pax_s2 + sq_pay_s2;
			db_s3    <= sq_pbx_s2 + sq_pby_s2;
			crs_s3   <= mag(cr);
			dcm_s3   <= mag(dc);
			dcneg_s3 <= dc[SUM_BITS-1];
			dta_s3   <= dta;
			dtb_s3   <= dtb;
			r2_s3    <= r2_s2;
			r_s3     <= r_s2;

			lhs_s4   <= cpa_s3 * cpa_s3;
			rhs_s4   <= r2_s3 * d2_s3;
			// project from the point farther from the centre
			dtm_s4   <= mag((da_s3 < db_s3) ? dta_s3 : dtb_s3);
			ta_s4    <= (da_s3 > MAG_BITS'(r2_s3)) ? da_s3 - MAG_BITS'(r2_s3) : '0;
			tb_s4    <= (db_s3 > MAG_BITS'(r2_s3)) ? db_s3 - MAG_BITS'(r2_s3) : '0;
			d2_s4    <= d2_s3;
			crs_s4   <= crs_s3;
			dcm_s4   <= dcm_s3;
			dcneg_s4 <= dcneg_s3;
			r_s4     <= r_s3;
		end
	end

	always_comb begin
		push_item.straight = (lhs_s4 >= (2*MAG_BITS)'(rhs_s4)) || (dtm_s4 >= d2_s4);
		push_item.r        = r_s4;
		push_item.d2       = d2_s4;
		push_item.ta       = ta_s4;
		push_item.tb       = tb_s4;
		push_item.crs      = crs_s4;
		push_item.dcm      = dcm_s4;
		push_item.dcneg    = dcneg_s4;
	end

endmodule

// ===== hw/rtl/col_fifo.sv =====
// Short queue of classified queries between front and back.
// Uses col_pkg for item_t, q_stat_t and the queue depth (a power of two).
module col_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  col_pkg::item_t   push_item,
	input  logic             pop,
	output col_pkg::item_t   head,
	output col_pkg::q_stat_t q_stat
);
	import col_pkg::*;

	item_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign q_stat.full  = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full && !pop)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty)) else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_BITS+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ===== hw/rtl/col_back.sv =====
// Back end: pipelined square roots, CORDIC angles, arc length and output register.
// Uses col_pkg; pops classified queries from col_fifo.
module col_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  col_pkg::q_stat_t              q_stat,
	input  col_pkg::item_t                head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [col_pkg::LEN_BITS-1:0]  path_length,
	output logic                          wrapped
);
	import col_pkg::*;

	localparam int CO_STAGES = NORM_STEPS + CORDIC_STEPS;

	logic                   en;
	logic [BACK_STAGES-1:0] vld_q;

	sq_t   sq_in  [NUM_LANES][SQRT_STEPS];
	sq_t   sq_q   [NUM_LANES][SQRT_STEPS];
	sqsb_t sqsb_q [SQRT_STEPS];

	nv_t   nv_in  [NUM_LANES][NORM_STEPS];
	nv_t   nv_q   [NUM_LANES][NORM_STEPS];
	cs_t   cs_in  [NUM_LANES][CORDIC_STEPS];
	cs_t   cs_q   [NUM_LANES][CORDIC_STEPS];
	cosb_t cosb_in;
	cosb_t cosb_q [CO_STAGES];

	logic [QA_BITS-1:0]    ang [NUM_LANES];
	logic [THETA_BITS-1:0] theta_q;
	logic [QA_BITS-1:0]    a1_q, a2_q;
	cosb_t                 fsb1_q, fsb2_q, fsb3_q;
	logic signed [THETA_BITS:0] arc_d;
	logic [THETA_BITS-1:0] arc_q;
	logic [PROD_BITS-1:0]  prod_q, arc_len;
	logic [PROD_BITS:0]    tot;
	logic [LEN_BITS-1:0]   len_q;
	logic                  wrap_q;

	// freeze every stage while the finished result waits
	assign en        = !(vld_q[BACK_STAGES-1] && out_stall);
	assign pop       = en && !q_stat.empty;
	assign out_valid = vld_q[BACK_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[BACK_STAGES-2:0], pop};
	end

	always_comb begin
		sq_in[0][0] = '{x: head.d2, rem: '0, root: '0};
		sq_in[1][0] = '{x: head.ta, rem: '0, root: '0};
		sq_in[2][0] = '{x: head.tb, rem: '0, root: '0};
		for (int l = 0; l < NUM_LANES; l++) begin
			for (int k = 1; k < SQRT_STEPS; k++)
				sq_in[l][k] = sq_q[l][k-1];
		end
	end

	always_comb begin
		cosb_in.straight = sqsb_q[SQRT_STEPS-1].straight;
		cosb_in.r        = sqsb_q[SQRT_STEPS-1].r;
		cosb_in.d2r      = sq_q[0][SQRT_STEPS-1].root;
		cosb_in.t1       = sq_q[1][SQRT_STEPS-1].root;
		cosb_in.t2       = sq_q[2][SQRT_STEPS-1].root;
		cosb_in.dcneg    = sqsb_q[SQRT_STEPS-1].dcneg;
		// centre angle uses (|cross|, |dot|); tangent angles use (T, r in fixed point)
		nv_in[0][0].x = NORM_BITS'(sqsb_q[SQRT_STEPS-1].dcm);
		nv_in[0][0].y = NORM_BITS'(sqsb_q[SQRT_STEPS-1].crs);
		nv_in[1][0].x = NORM_BITS'(sqsb_q[SQRT_STEPS-1].r) << FRAC_BITS;
		nv_in[1][0].y = NORM_BITS'(sq_q[1][SQRT_STEPS-1].root);
		nv_in[2][0].x = NORM_BITS'(sqsb_q[SQRT_STEPS-1].r) << FRAC_BITS;
		nv_in[2][0].y = NORM_BITS'(sq_q[2][SQRT_STEPS-1].root);
		for (int l = 0; l < NUM_LANES; l++) begin
			cosb_in.zero[l] = ((nv_in[l][0].x | nv_in[l][0].y) == '0);
			for (int n = 1; n < NORM_STEPS; n++)
				nv_in[l][n] = nv_q[l][n-1];
			cs_in[l][0].x = CX_BITS'(nv_q[l][NORM_STEPS-1].x);
			cs_in[l][0].y = CX_BITS'(nv_q[l][NORM_STEPS-1].y);
			cs_in[l][0].z = '0;
			for (int c = 1; c < CORDIC_STEPS; c++)
				cs_in[l][c] = cs_q[l][c-1];
			ang[l] = clamp_ang(cs_q[l][CORDIC_STEPS-1].z, cosb_q[CO_STAGES-1].zero[l]);
		end
	end

	always_comb begin
		arc_d   = $signed({1'b0, theta_q}) - $signed({2'b00, a1_q}) - $signed({2'b00, a2_q});
		arc_len = (prod_q + (PROD_BITS'(1) << (ARC_RND_SH - 1))) >> ARC_RND_SH;
		if (fsb3_q.straight)
			tot = (PROD_BITS+1)'(fsb3_q.d2r);
		else
			tot = (PROD_BITS+1)'(arc_len) + (PROD_BITS+1)'(fsb3_q.t1)
				+ (PROD_BITS+1)'(fsb3_q.t2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				for (int k = 0; k < SQRT_STEPS; k++)
					sq_q[l][k] <= sqrt_step(sq_in[l][k]);
				for (int n = 0; n < NORM_STEPS; n++)
					nv_q[l][n] <= norm_step(nv_in[l][n], n);
				for (int c = 0; c < CORDIC_STEPS; c++)
					cs_q[l][c] <= cordic_step(cs_in[l][c], c);
			end

			sqsb_q[0] <= '{straight: head.straight, r: head.r, crs: head.crs,
				dcm: head.dcm, dcneg: head.dcneg};
			for (int k = 1; k < SQRT_STEPS; k++)
				sqsb_q[k] <= sqsb_q[k-1];
			cosb_q[0] <= cosb_in;
			for (int j = 1; j < CO_STAGES; j++)
				cosb_q[j] <= cosb_q[j-1];

			theta_q <= cosb_q[CO_STAGES-1].dcneg ? PI_Q - THETA_BITS'(ang[0])
				: THETA_BITS'(ang[0]);
			a1_q    <= ang[1];
			a2_q    <= ang[2];
			fsb1_q  <= cosb_q[CO_STAGES-1];

			arc_q  <= arc_d[THETA_BITS] ? '0 : arc_d[THETA_BITS-1:0];
			fsb2_q <= fsb1_q;

			prod_q <= PROD_BITS'(fsb2_q.r) * PROD_BITS'(arc_q);
			fsb3_q <= fsb2_q;

			len_q  <= (tot > (PROD_BITS+1)'({LEN_BITS{1'b1}})) ? {LEN_BITS{1'b1}}
				: tot[LEN_BITS-1:0];
			wrap_q <= !fsb3_q.straight;
		end
	end

	assign path_length = len_q;
	assign wrapped     = wrap_q;

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[BACK_STAGES-1] && out_stall) |=> $stable(vld_q))
		else $error("back pipeline moved while output stalled");

endmodule

// ===== hw/rtl/circle_obstacle_path_length.sv =====
// Shortest path between two points around a disc obstacle, Q17.12 length output.
// Top level: col_front, col_fifo and col_back; types and constants from col_pkg.
//
// Usage:
//   Input channel: in_valid/in_stall with start, end, centre and radius fields.
//   A query is taken on a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid/out_stall with path_length and wrapped; a result
//   is taken on an edge with out_valid high and out_stall low.
//   Throughput: one query per cycle while out_stall stays low, through fully pipelined
//   square root (one bit per stage) and CORDIC (one rotation per stage) lanes.
//   Stages: 4 front stages, one queue write and 67 back stages (27 root,
//   6 shift, 30 rotation, 4 arc and output), in that order.
//   A stalled output freezes the back pipeline; the 4-entry queue then fills
//   and the front raises in_stall once its last stage cannot push.
//   Reset (arst_n low) empties all pipelines and the queue; data registers keep their values.
module circle_obstacle_path_length (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [col_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [col_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [col_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [col_pkg::COORD_BITS-1:0] end_y,
	input  logic signed [col_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [col_pkg::COORD_BITS-1:0] center_y,
	input  logic [col_pkg::RAD_BITS-1:0]          radius,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [col_pkg::LEN_BITS-1:0]          path_length,
	output logic                                  wrapped
);
	import col_pkg::*;

	q_stat_t q_stat;
	logic    push, pop;
	item_t   push_item, head;

	col_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	col_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	col_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.path_length (path_length),
		.wrapped     (wrapped)
	);

endmodule
